FILE: hw/rtl/rgbkc_pkg.sv
// Shared types, sizes, register codes and kernel tables for the 3x3 RGB convolution.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rgbkc_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int ROW_BYTES   = 3 * MAX_WIDTH;

	localparam int PIX_W       = 8;
	localparam int DIM_W       = 11;
	localparam int ROW_W       = 10;
	localparam int COL_W       = 12;
	localparam int KSEL_W      = 3;
	localparam int NUM_KERNELS = 8;
	localparam int NUM_TAPS    = 9;
	localparam int WGT_W       = 11;
	localparam int SUM_W       = 20;
	localparam int SUMP_W      = 18;
	localparam int RECIP_W     = 21;
	localparam int SHIFT_W     = 5;
	localparam int QPROD_W     = SUMP_W + RECIP_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SELECT = 2'd2;

	localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST   = 11'd640;
	localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST  = 11'd480;
	localparam logic [KSEL_W-1:0] KERNEL_SELECT_RST = 3'd0;
	localparam logic [DIM_W-1:0]  MIN_WIDTH_DIM     = 11'd2;
	localparam logic [DIM_W-1:0]  MIN_HEIGHT_DIM    = 11'd1;
	localparam logic [DIM_W-1:0]  MAX_WIDTH_DIM     = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0]  MAX_HEIGHT_DIM    = DIM_W'(MAX_HEIGHT);

	// Rows: blur, gaussian, box, sharpen, unsharpen, edge, horizontal and vertical Sobel.
	localparam int KERN_W [NUM_KERNELS][NUM_TAPS] = '{
		'{1, 1, 1, 1, 1, 1, 1, 1, 1},
		'{45, 122, 45, 122, 332, 122, 45, 122, 45},
		'{111, 111, 111, 111, 111, 111, 111, 111, 111},
		'{-1, -1, -1, -1, 16, -1, -1, -1, -1},
		'{-1, -1, -1, -1, 9, -1, -1, -1, -1},
		'{-125, -125, -125, -125, 1000, -125, -125, -125, -125},
		'{1, 2, 1, 0, 0, 0, -1, -2, -1},
		'{1, 0, -1, 2, 0, -2, 1, 0, -1}
	};

	// The divisor is applied as a multiply by a rounded-up reciprocal and a right shift.
	localparam int KERN_RECIP [NUM_KERNELS] = '{1864136, 268436, 268436, 1, 1, 268436, 1, 1};
	localparam int KERN_SHIFT [NUM_KERNELS] = '{24, 28, 28, 3, 0, 28, 0, 0};

	typedef struct packed {
		logic [PIX_W-1:0] sample;
		logic             frame_start;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] filtered;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_byte_col;
	} out_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
	} line_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_taps_t;

	typedef struct packed {
		logic             emit;
		logic             left_repair;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
	} pos_info_t;

	typedef logic [NUM_TAPS-1:0][PIX_W-1:0] tap_set_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rgbkc_line_store.sv
// Two-row line memory holding the rows above the current one, with read-modify-write.
// Depends on rgbkc_pkg for sizes and the memory word and tap column types.
`default_nettype none

module rgbkc_line_store (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            accept,
	input  wire logic [rgbkc_pkg::COL_W-1:0]     addr,
	input  wire logic [rgbkc_pkg::PIX_W-1:0]     sample,
	output logic                                 tap_valid,
	output rgbkc_pkg::col_taps_t                 taps
);
	import rgbkc_pkg::*;

	line_word_t       mem [ROW_BYTES];
	line_word_t       rd_data_s1;
	line_word_t       fwd_word_s1;
	line_word_t       eff_word;
	logic             v_s1;
	logic             fwd_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] sample_s1;
	logic             wr;

	// A write to the same column lands on the edge of the next read, so that read is forwarded.
	assign eff_word  = fwd_s1 ? fwd_word_s1 : rd_data_s1;
	assign wr        = en && v_s1;
	assign tap_valid = v_s1;
	assign taps      = '{top: eff_word.top, mid: eff_word.mid, bot: sample_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (en) begin
			v_s1   <= accept;
			fwd_s1 <= accept && v_s1 && (col_s1 == addr);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1           <= addr;
			sample_s1        <= sample;
			fwd_word_s1.top  <= eff_word.mid;
			fwd_word_s1.mid  <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[col_s1] <= '{top: eff_word.mid, mid: sample_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= mem[addr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbkc_window.sv
// Three-row by seven-column sliding window of same-channel bytes and its nine tap outputs.
// Depends on rgbkc_pkg for the tap column and tap set types.
`default_nettype none

module rgbkc_window (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 shift,
	input  wire rgbkc_pkg::col_taps_t col_in,
	input  wire logic                 left_repair,
	output rgbkc_pkg::tap_set_t       taps
);
	import rgbkc_pkg::*;

	logic [PIX_W-1:0] win_q [3][7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 7; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else if (shift) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 6; k++) begin
					win_q[r][k] <= win_q[r][k+1];
				end
			end
			win_q[0][6] <= col_in.top;
			win_q[1][6] <= col_in.mid;
			win_q[2][6] <= col_in.bot;
		end
	end

	// Near the row start the left neighbor is replaced by pixel 0 of the same channel.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			taps[r*3]     = left_repair ? win_q[r][3] : win_q[r][0];
			taps[r*3 + 1] = win_q[r][3];
			taps[r*3 + 2] = win_q[r][6];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbkc_arith.sv
// Weighted sum, division by the kernel divisor and clamping, as a registered pipeline.
// Depends on rgbkc_pkg for the kernel tables, widths and item types.
`default_nettype none

module rgbkc_arith (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire rgbkc_pkg::tap_set_t           taps,
	input  wire rgbkc_pkg::pos_info_t          info,
	input  wire logic [rgbkc_pkg::KSEL_W-1:0]  kernel_select,
	output logic                               out_valid,
	output rgbkc_pkg::out_item_t               result
);
	import rgbkc_pkg::*;

	logic signed [WGT_W-1:0]  wgt    [NUM_TAPS];
	logic signed [SUM_W-1:0]  prod_c [NUM_TAPS];
	logic signed [SUM_W-1:0]  prod_s3 [NUM_TAPS];
	logic signed [SUM_W-1:0]  row_sum [3];
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W-1:0]  sum_s4;
	logic                     pos_c;
	logic [QPROD_W-1:0]       q_s5;
	logic                     pos_s5;
	logic [QPROD_W-1:0]       quot;
	logic [SHIFT_W-1:0]       shift;
	logic [RECIP_W-1:0]       recip;
	logic                     v_s3;
	logic                     v_s4;
	logic                     v_s5;
	pos_info_t                info_s3;
	pos_info_t                info_s4;
	pos_info_t                info_s5;

	always_comb begin
		for (int t = 0; t < NUM_TAPS; t++) begin
			wgt[t]    = WGT_W'(KERN_W[kernel_select][t]);
			prod_c[t] = $signed({1'b0, taps[t]}) * wgt[t];
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = prod_s3[r*3] + prod_s3[r*3 + 1] + prod_s3[r*3 + 2];
		end
		sum_c = row_sum[0] + row_sum[1] + row_sum[2];
	end

	assign pos_c = !sum_s4[SUM_W-1] && (sum_s4 != '0);
	assign recip = RECIP_W'(KERN_RECIP[kernel_select]);
	assign shift = SHIFT_W'(KERN_SHIFT[kernel_select]);
	assign quot  = q_s5 >> shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_c;
			info_s3 <= info;
			sum_s4  <= sum_c;
			info_s4 <= info_s3;
			q_s5    <= QPROD_W'(sum_s4[SUMP_W-1:0]) * QPROD_W'(recip);
			pos_s5  <= pos_c;
			info_s5 <= info_s4;
		end
	end

	assign out_valid           = v_s5;
	assign result.out_row      = info_s5.out_row;
	assign result.out_byte_col = info_s5.out_col;

	always_comb begin
		if (!pos_s5) begin
			result.filtered = '0;
		end else if (|quot[QPROD_W-1:PIX_W]) begin
			result.filtered = '1;
		end else begin
			result.filtered = quot[PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbkc_out_buffer.sv
// Output register with one skid entry between the pipeline and the result channel.
// Depends on rgbkc_pkg for the result item type.
`default_nettype none

module rgbkc_out_buffer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire rgbkc_pkg::out_item_t push_item,
	input  wire logic                 result_stall,
	output logic                      result_valid,
	output rgbkc_pkg::out_item_t      result_item,
	output logic                      full
);
	import rgbkc_pkg::*;

	out_item_t out_q;
	out_item_t skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;
	logic      take;

	assign take         = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;
	assign full         = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_q <= push_item;
			end else begin
				out_q <= push_item;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_3x3_kernel_convolution_top.sv
// Top level of the streaming 3x3 convolution over interleaved RGB bytes.
// Depends on rgbkc_pkg and on rgbkc_line_store, rgbkc_window, rgbkc_arith, rgbkc_out_buffer.
//
//   Channel   Handshake                   Payload
//   sample    sample_valid / sample_stall sample_item (sample, frame_start)
//   result    result_valid / result_stall result_item (filtered, out_row, out_byte_col)
//   config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One transaction per cycle in both directions while no stall is raised, set by the single
// read and single write of the line memory for each byte.
// The line memory is not cleared after reset; the window and counters are.
// sample_stall is high while the skid entry of the output holds a result.
`default_nettype none

module rgb_3x3_kernel_convolution_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire rgbkc_pkg::in_item_t               sample_item,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output rgbkc_pkg::out_item_t                   result_item,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rgbkc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rgbkc_pkg::DIM_W-1:0]       cfg_data
);
	import rgbkc_pkg::*;

	logic [DIM_W-1:0]  frame_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	logic [KSEL_W-1:0] kernel_select_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;

	logic [DIM_W-1:0]  eff_w;
	logic [DIM_W-1:0]  eff_h;
	logic [COL_W-1:0]  rowlen;
	logic [COL_W-1:0]  c0;
	logic [COL_W-1:0]  col;
	logic [COL_W-1:0]  next_col;
	logic [DIM_W-1:0]  r1;
	logic [DIM_W-1:0]  next_row;
	logic [ROW_W-1:0]  row;
	pos_info_t         info_c;

	logic              en;
	logic              full;
	logic              accept;
	logic              tap_valid;
	col_taps_t         col_taps;
	tap_set_t          taps;
	pos_info_t         info_s1;
	pos_info_t         info_s2;
	logic              v_s2;
	logic              push_valid;
	out_item_t         push_item;

	assign en           = !full;
	assign sample_stall = full;
	assign accept       = sample_valid && en;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			kernel_select_q <= KERNEL_SELECT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data;
				CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data;
				CFG_KERNEL_SELECT: kernel_select_q <= cfg_data[KSEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < MIN_WIDTH_DIM) begin
			eff_w = MIN_WIDTH_DIM;
		end else if (frame_width_q > MAX_WIDTH_DIM) begin
			eff_w = MAX_WIDTH_DIM;
		end else begin
			eff_w = frame_width_q;
		end
		if (frame_height_q < MIN_HEIGHT_DIM) begin
			eff_h = MIN_HEIGHT_DIM;
		end else if (frame_height_q > MAX_HEIGHT_DIM) begin
			eff_h = MAX_HEIGHT_DIM;
		end else begin
			eff_h = frame_height_q;
		end
		rowlen = ({1'b0, eff_w} << 1) + {1'b0, eff_w};
	end

	// The column can only be past the row end here after a width change within a frame.
	always_comb begin
		c0 = sample_item.frame_start ? '0 : col_q;
		r1 = sample_item.frame_start ? '0 : {1'b0, row_q};
		if (c0 >= rowlen) begin
			col = '0;
			r1  = r1 + 1'b1;
		end else begin
			col = c0;
		end
		row      = (r1 >= eff_h) ? '0 : r1[ROW_W-1:0];
		next_col = col + 1'b1;
		next_row = {1'b0, row} + 1'b1;

		info_c.emit        = (row >= ROW_W'(2)) && (({1'b0, row} + DIM_W'(3)) <= eff_h)
			&& (col >= COL_W'(4));
		info_c.left_repair = col < COL_W'(6);
		info_c.out_row     = row - 1'b1;
		info_c.out_col     = col - COL_W'(3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (next_col >= rowlen) begin
				col_q <= '0;
				row_q <= (next_row >= eff_h) ? '0 : next_row[ROW_W-1:0];
			end else begin
				col_q <= next_col;
				row_q <= row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= tap_valid && info_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info_c;
		end
		if (en) begin
			info_s2 <= info_s1;
		end
	end

	rgbkc_line_store u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.accept    (accept),
		.addr      (col),
		.sample    (sample_item.sample),
		.tap_valid (tap_valid),
		.taps      (col_taps)
	);

	rgbkc_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift       (en && tap_valid),
		.col_in      (col_taps),
		.left_repair (info_s2.left_repair),
		.taps        (taps)
	);

	rgbkc_arith u_arith (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (v_s2),
		.taps          (taps),
		.info          (info_s2),
		.kernel_select (kernel_select_q),
		.out_valid     (push_valid),
		.result        (push_item)
	);

	rgbkc_out_buffer u_out_buffer (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (en && push_valid),
		.push_item    (push_item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_item  (result_item),
		.full         (full)
	);

endmodule

`default_nettype wire
